// ===== src/tcq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcq_pkg: shared types and constants for the two-class age-ordered queue
// Command and status codes, class codes, lane control and status structs.
// ----------------------------------------------------------------------------
package tcq_pkg;

    localparam int CMD_BITS       = 3;
    localparam int STATUS_BITS    = 2;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 8;
    localparam int DEF_STAMP_BITS  = 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_CAT   = 3'd0,
        CMD_PUSH_DOG   = 3'd1,
        CMD_POP_DOG    = 3'd2,
        CMD_POP_CAT    = 3'd3,
        CMD_POP_OLDEST = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic CLS_CAT = 1'b0;
    localparam logic CLS_DOG = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } t_lane_ctl;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_lane_stat;

endpackage

// ===== src/tcq_if.sv =====
// ----------------------------------------------------------------------------
// tcq_in_if / tcq_out_if: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tcq_in_if
    import tcq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
);
    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] cmd;
    logic [TAG_BITS-1:0] item_tag;

    modport source (output valid, output cmd, output item_tag, input ready);
    modport sink   (input valid, input cmd, input item_tag, output ready);
endinterface

interface tcq_out_if
    import tcq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   got_item;
    logic                   got_class;
    logic [TAG_BITS-1:0]    got_tag;
    logic                   cat_is_empty;
    logic                   dog_is_empty;

    modport source (output valid, output status, output got_item, output got_class,
                    output got_tag, output cat_is_empty, output dog_is_empty,
                    input ready);
    modport sink   (input valid, input status, input got_item, input got_class,
                    input got_tag, input cat_is_empty, input dog_is_empty,
                    output ready);
endinterface

// ===== src/tcq_cell.sv =====
// ----------------------------------------------------------------------------
// tcq_cell: one storage cell of a class queue
// Loads a new entry at the tail, or takes its neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module tcq_cell
    import tcq_pkg::*;
#(
    parameter int ENTRY_BITS = DEF_TAG_BITS + DEF_STAMP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_shift,
    input  logic [ENTRY_BITS-1:0] i_load_data,
    input  logic [ENTRY_BITS-1:0] i_next_data,
    output logic [ENTRY_BITS-1:0] o_data
);
    logic [ENTRY_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;
endmodule

// ===== src/tcq_lane.sv =====
// ----------------------------------------------------------------------------
// tcq_lane: one class queue built as a chain of cells
// Head sits in cell 0; a pop shifts every cell one step toward the head.
// ----------------------------------------------------------------------------
module tcq_lane
    import tcq_pkg::*;
#(
    parameter int DEPTH      = DEF_QUEUE_DEPTH,
    parameter int ENTRY_BITS = DEF_TAG_BITS + DEF_STAMP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_ctl             i_ctl,
    input  logic [ENTRY_BITS-1:0] i_entry,
    output logic [ENTRY_BITS-1:0] o_head,
    output t_lane_stat            o_stat
);
    localparam int FILL_BITS = $clog2(DEPTH + 1);

    logic [FILL_BITS-1:0]  r_fill;
    logic [FILL_BITS-1:0]  n_fill;
    logic [ENTRY_BITS-1:0] w_data [DEPTH];

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.push) begin
            n_fill = r_fill + FILL_BITS'(1);
        end else if (i_ctl.pop) begin
            n_fill = r_fill - FILL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        // last cell keeps its own word on a shift; it is beyond the fill then
        tcq_cell #(
            .ENTRY_BITS (ENTRY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctl.push && (r_fill == FILL_BITS'(i))),
            .i_shift     (i_ctl.pop),
            .i_load_data (i_entry),
            .i_next_data (w_data[(i == DEPTH - 1) ? i : i + 1]),
            .o_data      (w_data[i])
        );
    end

    assign o_head       = w_data[0];
    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_BITS'(DEPTH));
    assign o_stat.one   = (r_fill == FILL_BITS'(1));
endmodule

// ===== src/two_class_age_ordered_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue: cat/dog queue with shared arrival stamps
//
// Command channel i_in carries cmd and item_tag; result channel o_out
// carries one result word per command: status, got_item, got_class,
// got_tag and both empty flags after the command.
// A push stamps the tag with the arrival counter and appends it to its
// class queue; a pop takes a class head; pop oldest serves the head with
// the older stamp (wrap-aware compare).
// The result word is registered in the cycle after a command is taken;
// one command per cycle is sustained unless o_out stalls. Each queue is
// a chain of cells, head first, so a command touches one head or tail.
// The result register frees in the cycle it is taken, so a new command
// is accepted whenever o_out is empty or o_out.ready is high.
// Synchronous reset empties both queues, clears the arrival counter and
// drops any pending result. A stalled receiver holds the result and
// backpressures the command channel.
// ----------------------------------------------------------------------------
module two_class_age_ordered_queue
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcq_in_if.sink   i_in,
    tcq_out_if.source o_out
);
    localparam int ENTRY_BITS = TAG_BITS + STAMP_BITS;

    logic [STAMP_BITS-1:0] r_stamp;
    logic                  r_valid;
    t_status               r_status;
    logic                  r_got_item;
    logic                  r_got_class;
    logic [TAG_BITS-1:0]   r_got_tag;
    logic                  r_cat_empty;
    logic                  r_dog_empty;

    t_status               n_status;
    logic                  n_got_item;
    logic                  n_got_class;
    logic [TAG_BITS-1:0]   n_got_tag;

    t_lane_ctl             w_cat_ctl;
    t_lane_ctl             w_dog_ctl;
    t_lane_stat            w_cat_stat;
    t_lane_stat            w_dog_stat;
    logic [ENTRY_BITS-1:0] w_cat_head;
    logic [ENTRY_BITS-1:0] w_dog_head;
    logic [ENTRY_BITS-1:0] w_entry;
    logic [STAMP_BITS-1:0] w_stamp_diff;
    logic                  w_accept;
    logic                  w_pick_valid;
    logic                  w_pick;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_entry    = {r_stamp, i_in.item_tag};

    assign w_stamp_diff = w_cat_head[ENTRY_BITS-1:TAG_BITS]
                        - w_dog_head[ENTRY_BITS-1:TAG_BITS];

    always_comb begin
        w_cat_ctl    = '0;
        w_dog_ctl    = '0;
        w_pick_valid = 1'b0;
        w_pick       = CLS_CAT;
        n_status     = ST_OK;
        n_got_item   = 1'b0;
        n_got_class  = CLS_CAT;
        n_got_tag    = '0;

        unique case (i_in.cmd)
            CMD_PUSH_CAT: begin
                if (w_cat_stat.full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cat_ctl.push = w_accept;
                end
            end
            CMD_PUSH_DOG: begin
                if (w_dog_stat.full) begin
                    n_status = ST_FULL;
                end else begin
                    w_dog_ctl.push = w_accept;
                end
            end
            CMD_POP_CAT: begin
                w_pick_valid = 1'b1;
                w_pick       = CLS_CAT;
            end
            CMD_POP_DOG: begin
                w_pick_valid = 1'b1;
                w_pick       = CLS_DOG;
            end
            CMD_POP_OLDEST: begin
                w_pick_valid = 1'b1;
                // empty cat side serves dog; otherwise older stamp wins
                if (w_cat_stat.empty) begin
                    w_pick = CLS_DOG;
                end else if (w_dog_stat.empty) begin
                    w_pick = CLS_CAT;
                end else begin
                    w_pick = w_stamp_diff[STAMP_BITS-1] ? CLS_CAT : CLS_DOG;
                end
            end
            default: begin
            end
        endcase

        if (w_pick_valid) begin
            if (w_pick == CLS_CAT) begin
                if (w_cat_stat.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cat_ctl.pop = w_accept;
                    n_got_item    = 1'b1;
                    n_got_class   = CLS_CAT;
                    n_got_tag     = w_cat_head[TAG_BITS-1:0];
                end
            end else begin
                if (w_dog_stat.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_dog_ctl.pop = w_accept;
                    n_got_item    = 1'b1;
                    n_got_class   = CLS_DOG;
                    n_got_tag     = w_dog_head[TAG_BITS-1:0];
                end
            end
        end
    end

    tcq_lane #(
        .DEPTH      (QUEUE_DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_cat_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cat_ctl),
        .i_entry (w_entry),
        .o_head  (w_cat_head),
        .o_stat  (w_cat_stat)
    );

    tcq_lane #(
        .DEPTH      (QUEUE_DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_dog_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dog_ctl),
        .i_entry (w_entry),
        .o_head  (w_dog_head),
        .o_stat  (w_dog_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_cat_ctl.push || w_dog_ctl.push) begin
                r_stamp <= r_stamp + STAMP_BITS'(1);
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result word; empty flags reflect the queues after this command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_got_item  <= n_got_item;
            r_got_class <= n_got_class;
            r_got_tag   <= n_got_tag;
            r_cat_empty <= w_cat_ctl.push ? 1'b0 :
                           w_cat_ctl.pop  ? w_cat_stat.one : w_cat_stat.empty;
            r_dog_empty <= w_dog_ctl.push ? 1'b0 :
                           w_dog_ctl.pop  ? w_dog_stat.one : w_dog_stat.empty;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_status;
    assign o_out.got_item     = r_got_item;
    assign o_out.got_class    = r_got_class;
    assign o_out.got_tag      = r_got_tag;
    assign o_out.cat_is_empty = r_cat_empty;
    assign o_out.dog_is_empty = r_dog_empty;
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_class_age_ordered_queue
// Sends command words with random gaps and checks every result word against
// a cycle-free predictor of the two class queues and the arrival stamp.
// The receiver stalls at random and once holds off long enough to back up
// the command channel.
// ----------------------------------------------------------------------------
module testbench;
    import tcq_pkg::*;

    localparam int DEPTH   = DEF_QUEUE_DEPTH;
    localparam int TAG_W   = DEF_TAG_BITS;
    localparam int STAMP_W = DEF_STAMP_BITS;

    localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = CMD_BITS'(CMD_POP_OLDEST + 1);
    localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = '1;

    localparam int RANDOM_ITEMS = 360;
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
    } t_pet;

    typedef struct {
        t_status          status;
        logic             got_item;
        logic             got_class;
        logic [TAG_W-1:0] got_tag;
        logic             cat_empty;
        logic             dog_empty;
    } t_outcome;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        logic [TAG_W-1:0]    tag;
        bit                  wait_drain;
        int                  trail_gap;
    } t_order;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcq_in_if  #(.TAG_BITS(TAG_W)) cmd_ch ();
    tcq_out_if #(.TAG_BITS(TAG_W)) res_ch ();

    two_class_age_ordered_queue #(
        .QUEUE_DEPTH(DEPTH),
        .TAG_BITS   (TAG_W),
        .STAMP_BITS (STAMP_W)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    // predictor state
    t_pet               cat_line[$];
    t_pet               dog_line[$];
    logic [STAMP_W-1:0] next_stamp;

    t_outcome outcome_due[$];
    t_order   cmd_backlog[$];

    int  errors = 0;
    int  words_in = 0;
    bit  cmd_taken = 0;
    int  idle_left = 0;
    int  stall_left = 0;
    int  rx_tick = 0;
    int  rx_roll;
    bit  hold_rx = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = CMD_PUSH_CAT;
        cmd_ch.item_tag = '0;
        res_ch.ready    = 1'b0;
        next_stamp      = '0;
    end

    function automatic t_outcome adopt_outcome(input logic [CMD_BITS-1:0] cmd,
                                               input logic [TAG_W-1:0] tag);
        t_outcome           res;
        t_pet               head;
        logic [STAMP_W-1:0] age_gap;
        bit                 serving;
        logic               serve_cls;
        res.status    = ST_OK;
        res.got_item  = 1'b0;
        res.got_class = CLS_CAT;
        res.got_tag   = '0;
        serving       = 1'b0;
        serve_cls     = CLS_CAT;
        case (cmd)
            CMD_PUSH_CAT: begin
                if (cat_line.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head.stamp = next_stamp;
                    head.tag   = tag;
                    cat_line.push_back(head);
                    next_stamp = next_stamp + 1'b1;
                end
            end
            CMD_PUSH_DOG: begin
                if (dog_line.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head.stamp = next_stamp;
                    head.tag   = tag;
                    dog_line.push_back(head);
                    next_stamp = next_stamp + 1'b1;
                end
            end
            CMD_POP_CAT: begin
                serving   = 1'b1;
                serve_cls = CLS_CAT;
            end
            CMD_POP_DOG: begin
                serving   = 1'b1;
                serve_cls = CLS_DOG;
            end
            CMD_POP_OLDEST: begin
                serving = 1'b1;
                if (cat_line.size() == 0) begin
                    serve_cls = CLS_DOG;
                end else if (dog_line.size() == 0) begin
                    serve_cls = CLS_CAT;
                end else begin
                    // cat is older when the wrapped difference is negative
                    age_gap   = cat_line[0].stamp - dog_line[0].stamp;
                    serve_cls = age_gap[STAMP_W-1] ? CLS_CAT : CLS_DOG;
                end
            end
            default: ;
        endcase
        if (serving) begin
            if ((serve_cls == CLS_CAT && cat_line.size() == 0) ||
                (serve_cls == CLS_DOG && dog_line.size() == 0)) begin
                res.status = ST_EMPTY;
            end else begin
                if (serve_cls == CLS_CAT) begin
                    head = cat_line.pop_front();
                end else begin
                    head = dog_line.pop_front();
                end
                res.got_item  = 1'b1;
                res.got_class = serve_cls;
                res.got_tag   = head.tag;
            end
        end
        res.cat_empty = (cat_line.size() == 0);
        res.dog_empty = (dog_line.size() == 0);
        return res;
    endfunction

    task automatic note_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $time);
        end
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    task automatic add_order(input logic [CMD_BITS-1:0] cmd, input logic [TAG_W-1:0] tag,
                             input bit wait_drain, input int gap);
        t_order o;
        o.cmd        = cmd;
        o.tag        = tag;
        o.wait_drain = wait_drain;
        o.trail_gap  = gap;
        cmd_backlog.push_back(o);
    endtask

    // driver: offer the next word once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_ch.valid && !cmd_taken) begin
            // hold the word until accepted
        end else if (idle_left > 0) begin
            cmd_ch.valid <= 1'b0;
            idle_left--;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].wait_drain && outcome_due.size() != 0)) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            cmd_ch.valid    <= 1'b1;
            cmd_ch.cmd      <= cmd_backlog[0].cmd;
            cmd_ch.item_tag <= cmd_backlog[0].tag;
            idle_left = cmd_backlog[0].trail_gap;
            void'(cmd_backlog.pop_front());
        end
    end

    // receiver ready: steady stretches, short and long stalls, one long hold
    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_rx) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else if (rx_tick % 300 < 60) begin
            res_ch.ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 65) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                stall_left = (rx_roll < 92) ? $urandom_range(0, 2) : $urandom_range(6, 25);
            end
        end
    end

    initial begin
        while (words_in < LONG_HOLD_AT) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // monitor: check result words, then predict accepted command words
    always @(posedge i_clk) begin
        t_outcome want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (outcome_due.size() == 0) begin
                    note_mismatch("unexpected result word", 1, 0);
                end else begin
                    want = outcome_due.pop_front();
                    if (res_ch.status !== want.status)
                        note_mismatch("status", res_ch.status, want.status);
                    if (res_ch.got_item !== want.got_item)
                        note_mismatch("got_item", res_ch.got_item, want.got_item);
                    if (res_ch.got_class !== want.got_class)
                        note_mismatch("got_class", res_ch.got_class, want.got_class);
                    if (res_ch.got_tag !== want.got_tag)
                        note_mismatch("got_tag", res_ch.got_tag, want.got_tag);
                    if (res_ch.cat_is_empty !== want.cat_empty)
                        note_mismatch("cat_is_empty", res_ch.cat_is_empty, want.cat_empty);
                    if (res_ch.dog_is_empty !== want.dog_empty)
                        note_mismatch("dog_is_empty", res_ch.dog_is_empty, want.dog_empty);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                outcome_due.push_back(adopt_outcome(cmd_ch.cmd, cmd_ch.item_tag));
                cmd_taken = 1'b1;
                words_in++;
            end
        end
    end

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int  counted;
        int  phase_len;
        int  push_pct;
        int  r;
        bit  steady;
        bit  first;
        logic [CMD_BITS-1:0] c;

        // pops and spare codes on an empty block
        add_order(CMD_POP_CAT, 8'hFF, 1'b0, pick_gap(1'b0));
        add_order(CMD_POP_DOG, 8'h00, 1'b0, pick_gap(1'b0));
        add_order(CMD_POP_OLDEST, 8'hFF, 1'b0, pick_gap(1'b0));
        for (int s = CMD_SPARE_LO; s <= CMD_SPARE_HI; s++) begin
            add_order(s[CMD_BITS-1:0], 8'hFF, 1'b0, pick_gap(1'b0));
        end
        // fill cat past its depth behind one dog, then serve oldest twice
        add_order(CMD_PUSH_DOG, 8'h00, 1'b0, pick_gap(1'b0));
        add_order(CMD_PUSH_CAT, 8'hFF, 1'b0, pick_gap(1'b0));
        add_order(CMD_PUSH_CAT, 8'h00, 1'b0, pick_gap(1'b0));
        for (int k = 2; k < DEPTH; k++) begin
            add_order(CMD_PUSH_CAT, TAG_W'($urandom_range(0, 255)), 1'b0, pick_gap(1'b1));
        end
        add_order(CMD_PUSH_CAT, 8'hA5, 1'b0, pick_gap(1'b0));
        add_order(CMD_POP_OLDEST, 8'h5A, 1'b0, pick_gap(1'b0));
        add_order(CMD_POP_OLDEST, 8'h00, 1'b0, pick_gap(1'b0));

        // random phases that lean toward filling, draining or churning
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 50);
            steady    = ($urandom_range(0, 3) == 0);
            first     = ($urandom_range(0, 2) == 0) || (counted == 0);
            case ($urandom_range(0, 3))
                0:       push_pct = 80;
                1:       push_pct = 25;
                default: push_pct = 60;
            endcase
            for (int k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    c = CMD_BITS'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                end else begin
                    counted++;
                    if (r < 3 + push_pct * 97 / 100) begin
                        c = $urandom_range(0, 1) ? CMD_PUSH_DOG : CMD_PUSH_CAT;
                    end else begin
                        r = $urandom_range(0, 9);
                        c = (r < 4) ? CMD_POP_OLDEST : ((r < 7) ? CMD_POP_CAT : CMD_POP_DOG);
                    end
                end
                add_order(c, TAG_W'($urandom_range(0, 255)), first, pick_gap(steady));
                first = 1'b0;
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_ch.valid) @(posedge i_clk);
        while (outcome_due.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tcq_pkg.sv
src/tcq_if.sv
src/tcq_cell.sv
src/tcq_lane.sv
src/two_class_age_ordered_queue.sv
tb/testbench.sv
